>>> rtl/tasc_pkg.sv
// tasc_pkg: shared types and constants of the two-axis stepper slew controller
// used by tasc_timer and two_axis_stepper_slew_control_top, no dependencies
package tasc_pkg;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SLEW      = 3'd1,
    OP_ABORT     = 3'd2,
    OP_TRACK_ON  = 3'd3,
    OP_TRACK_OFF = 3'd4,
    OP_SET_POS   = 3'd5
  } op_e;

  // timer control from the top level
  typedef struct packed {
    logic advance;
    logic clear;
  } tmr_ctl_t;

  localparam int unsigned CFG_W      = 16;
  localparam int unsigned RA_W       = 22;
  localparam int unsigned DEC_W      = 24;
  localparam int unsigned DEC_TGT_W  = 21;
  localparam int unsigned IN_BYTES_W = 48;
  localparam int unsigned OUT_W      = 56;
  localparam logic [RA_W-1:0] STEPS_MAX = '1;

endpackage

>>> rtl/tasc_timer.sv
// tasc_timer: microsecond period timer for one step channel
// depends on tasc_pkg for tmr_ctl_t
module tasc_timer import tasc_pkg::*; #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tmr_ctl_t         ctl_i,
  input  logic [CFG_W-1:0] period_i,
  output logic             fire_o
);

  localparam int unsigned CW = ((PERIOD_BITS > CFG_W) ? PERIOD_BITS : CFG_W) + 1;
  localparam logic [CW-1:0] LIM = CW'(1) << PERIOD_BITS;

  logic [PERIOD_BITS-1:0] timer_q, timer_d;
  logic [CW-1:0]          per_ext, per_eff, nxt;

  // zero period acts as one, oversized period saturates at the timer range
  assign per_ext = CW'(period_i);
  assign per_eff = (per_ext == '0) ? CW'(1) : ((per_ext > LIM) ? LIM : per_ext);
  assign nxt     = CW'(timer_q) + CW'(1);
  assign fire_o  = (nxt >= per_eff);

  always_comb begin
    timer_d = timer_q;
    if (ctl_i.clear) begin
      timer_d = '0;
    end else if (ctl_i.advance) begin
      timer_d = fire_o ? '0 : nxt[PERIOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
    end else begin
      timer_q <= timer_d;
    end
  end

endmodule

>>> rtl/two_axis_stepper_slew_control_top.sv
// two_axis_stepper_slew_control_top: RA/DEC step generator with slew and tracking
// depends on tasc_pkg and tasc_timer
//
// usage: each input transaction on the s_axis channel carries one op on tuser (a 1 us
// tick, slew, abort, start/stop tracking or set position) and RA and DEC targets on tdata.
// every input transaction yields exactly one output transaction on m_axis with
// the pin levels, status flags and positions as they stand after that op.
// the state and the output register load at the edge that accepts the input, so
// m_axis_tvalid rises in the next cycle.
// throughput is one transaction per cycle while m_axis_tready is high; the slew deltas,
// wraps and timer compares all settle between the state and the output registers.
// s_axis_tready is high while the output register is empty or being taken, so
// a stalled receiver holds the current result and back-pressures the input.
// reset sets RA to 0, DEC to 90 degrees, both driver enable_n pins high, all timers
// and counts to zero, slew period 49 and track period 233.
// the APB port writes slew_period at address 0 and track_period at address 4;
// write it only while no transaction is in flight.
module two_axis_stepper_slew_control_top import tasc_pkg::*; #(
  parameter int unsigned STEPS_PER_DEG = 10240,
  parameter int unsigned PERIOD_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // ra_target[21:0], dec_target[42:22], zero fill [47:43]
  input  logic [IN_BYTES_W-1:0] s_axis_tdata,
  // op[2:0]
  input  logic [2:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // ra_step[0], ra_dir[1], ra_enable_n[2], dec_step[3], dec_dir[4],
  // dec_enable_n[5], slewing[6], tracking[7], ra_position[29:8],
  // dec_position[53:30], zero fill [55:54]
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned FULL_I = 360 * STEPS_PER_DEG;
  localparam int unsigned DW = $clog2((2 ** DEC_W) + (2 ** RA_W) + FULL_I) + 1;
  localparam logic signed [DW-1:0] FULL_TURN    = DW'(FULL_I);
  localparam logic signed [DW-1:0] HALF_TURN    = DW'(180 * STEPS_PER_DEG);
  localparam logic signed [DW-1:0] QUARTER_TURN = DW'(90 * STEPS_PER_DEG);
  localparam logic [DEC_W-1:0]     DEC_RESET    = DEC_W'(90 * STEPS_PER_DEG);

  // configuration
  logic [CFG_W-1:0] slew_period_q, track_period_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {16'b0, track_period_q} : {16'b0, slew_period_q};

  // state
  logic [RA_W-1:0]  ra_pos_q, ra_pos_d, ra_rem_q, ra_rem_d, dec_rem_q, dec_rem_d;
  logic [DEC_W-1:0] dec_pos_q, dec_pos_d;
  logic ra_up_q, ra_up_d, dec_up_q, dec_up_d;
  logic ra_act_q, ra_act_d, dec_act_q, dec_act_d, trk_act_q, trk_act_d;
  logic ra_ph_q, ra_ph_d, dec_ph_q, dec_ph_d, trk_ph_q, trk_ph_d;
  logic ra_step_q, ra_step_d, ra_dir_q, ra_dir_d, ra_en_n_q, ra_en_n_d;
  logic dec_step_q, dec_step_d, dec_dir_q, dec_dir_d, dec_en_n_q, dec_en_n_d;

  // output register
  logic             out_vld_q;
  logic [OUT_W-1:0] out_data_q;
  logic             s_fire;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // input fields
  op_e                         op;
  logic [RA_W-1:0]             ra_tgt;
  logic signed [DEC_TGT_W-1:0] dec_tgt;

  assign op      = op_e'(s_axis_tuser);
  assign ra_tgt  = s_axis_tdata[21:0];
  assign dec_tgt = s_axis_tdata[42:22];

  // timers
  tmr_ctl_t ra_tctl, dec_tctl, trk_tctl;
  logic     ra_fire, dec_fire, trk_fire;

  tasc_timer #(.PERIOD_BITS(PERIOD_BITS)) u_ra_timer (
    .clk_i, .rst_ni, .ctl_i(ra_tctl), .period_i(slew_period_q), .fire_o(ra_fire)
  );
  tasc_timer #(.PERIOD_BITS(PERIOD_BITS)) u_dec_timer (
    .clk_i, .rst_ni, .ctl_i(dec_tctl), .period_i(slew_period_q), .fire_o(dec_fire)
  );
  tasc_timer #(.PERIOD_BITS(PERIOD_BITS)) u_trk_timer (
    .clk_i, .rst_ni, .ctl_i(trk_tctl), .period_i(track_period_q), .fire_o(trk_fire)
  );

  // slew deltas, shortest way round
  logic signed [DW-1:0] dra_raw, dra, ddec_raw, ddec, dra_abs, ddec_abs;
  logic [RA_W-1:0]      ra_steps, dec_steps;
  logic signed [DW-1:0] ra_stepped;

  assign dra_raw  = signed'(DW'(ra_tgt)) - signed'(DW'(ra_pos_q));
  assign dra      = (dra_raw > HALF_TURN) ? dra_raw - FULL_TURN :
                    ((dra_raw < -HALF_TURN) ? dra_raw + FULL_TURN : dra_raw);
  assign ddec_raw = DW'(dec_tgt) - DW'(signed'(dec_pos_q));
  assign ddec     = (ddec_raw > QUARTER_TURN) ? ddec_raw - HALF_TURN :
                    ((ddec_raw < -QUARTER_TURN) ? ddec_raw + HALF_TURN : ddec_raw);
  assign dra_abs  = dra[DW-1] ? -dra : dra;
  assign ddec_abs = ddec[DW-1] ? -ddec : ddec;
  assign ra_steps  = (dra_abs > signed'(DW'(STEPS_MAX))) ? STEPS_MAX : dra_abs[RA_W-1:0];
  assign dec_steps = (ddec_abs > signed'(DW'(STEPS_MAX))) ? STEPS_MAX : ddec_abs[RA_W-1:0];

  // one RA step with wrap into a full turn
  logic signed [DW-1:0] ra_p;
  assign ra_p       = signed'(DW'(ra_pos_q)) + (ra_up_q ? DW'(1) : -DW'(1));
  assign ra_stepped = (ra_p > FULL_TURN) ? ra_p - FULL_TURN :
                      ((ra_p < 0) ? ra_p + FULL_TURN : ra_p);

  always_comb begin
    ra_pos_d   = ra_pos_q;
    dec_pos_d  = dec_pos_q;
    ra_rem_d   = ra_rem_q;
    dec_rem_d  = dec_rem_q;
    ra_up_d    = ra_up_q;
    dec_up_d   = dec_up_q;
    ra_act_d   = ra_act_q;
    dec_act_d  = dec_act_q;
    trk_act_d  = trk_act_q;
    ra_ph_d    = ra_ph_q;
    dec_ph_d   = dec_ph_q;
    trk_ph_d   = trk_ph_q;
    ra_step_d  = ra_step_q;
    ra_dir_d   = ra_dir_q;
    ra_en_n_d  = ra_en_n_q;
    dec_step_d = dec_step_q;
    dec_dir_d  = dec_dir_q;
    dec_en_n_d = dec_en_n_q;
    ra_tctl    = '0;
    dec_tctl   = '0;
    trk_tctl   = '0;
    if (s_fire) begin
      case (op)
        OP_TICK: begin
          ra_tctl.advance  = ra_act_q;
          dec_tctl.advance = dec_act_q;
          trk_tctl.advance = trk_act_q;
          if (ra_act_q && ra_fire) begin
            ra_step_d = ra_ph_q;
            ra_pos_d  = ra_stepped[RA_W-1:0];
            ra_ph_d   = !ra_ph_q;
            if (ra_rem_q <= RA_W'(1)) begin
              ra_rem_d  = '0;
              ra_act_d  = 1'b0;
              ra_en_n_d = 1'b1;
            end else begin
              ra_rem_d = ra_rem_q - RA_W'(1);
            end
          end
          if (dec_act_q && dec_fire) begin
            dec_step_d = dec_ph_q;
            dec_pos_d  = dec_up_q ? dec_pos_q + DEC_W'(1) : dec_pos_q - DEC_W'(1);
            dec_ph_d   = !dec_ph_q;
            if (dec_rem_q <= RA_W'(1)) begin
              dec_rem_d  = '0;
              dec_act_d  = 1'b0;
              dec_en_n_d = 1'b1;
            end else begin
              dec_rem_d = dec_rem_q - RA_W'(1);
            end
          end
          // tracking level wins over a same-tick slew step
          if (trk_act_q && trk_fire) begin
            ra_step_d = trk_ph_q;
            trk_ph_d  = !trk_ph_q;
          end
        end
        OP_SLEW: begin
          ra_up_d   = (dra > 0);
          dec_up_d  = (ddec > 0);
          ra_dir_d  = (dra > 0);
          dec_dir_d = (ddec > 0);
          if (dec_steps != '0) begin
            dec_en_n_d     = 1'b0;
            dec_rem_d      = dec_steps;
            dec_act_d      = 1'b1;
            dec_tctl.clear = 1'b1;
          end
          if (ra_steps != '0) begin
            ra_en_n_d     = 1'b0;
            ra_rem_d      = ra_steps;
            ra_act_d      = 1'b1;
            ra_tctl.clear = 1'b1;
          end
        end
        OP_ABORT: begin
          ra_en_n_d      = 1'b1;
          dec_en_n_d     = 1'b1;
          ra_act_d       = 1'b0;
          dec_act_d      = 1'b0;
          ra_rem_d       = '0;
          dec_rem_d      = '0;
          ra_tctl.clear  = 1'b1;
          dec_tctl.clear = 1'b1;
        end
        OP_TRACK_ON: begin
          ra_en_n_d      = 1'b0;
          ra_dir_d       = 1'b0;
          trk_act_d      = 1'b1;
          trk_tctl.clear = 1'b1;
        end
        OP_TRACK_OFF: begin
          ra_en_n_d = 1'b1;
          trk_act_d = 1'b0;
        end
        OP_SET_POS: begin
          ra_pos_d  = ra_tgt;
          dec_pos_d = DEC_W'(dec_tgt);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slew_period_q  <= CFG_W'(49);
      track_period_q <= CFG_W'(233);
      ra_pos_q   <= '0;
      dec_pos_q  <= DEC_RESET;
      ra_rem_q   <= '0;
      dec_rem_q  <= '0;
      ra_up_q    <= 1'b0;
      dec_up_q   <= 1'b0;
      ra_act_q   <= 1'b0;
      dec_act_q  <= 1'b0;
      trk_act_q  <= 1'b0;
      ra_ph_q    <= 1'b0;
      dec_ph_q   <= 1'b0;
      trk_ph_q   <= 1'b0;
      ra_step_q  <= 1'b0;
      ra_dir_q   <= 1'b0;
      ra_en_n_q  <= 1'b1;
      dec_step_q <= 1'b0;
      dec_dir_q  <= 1'b0;
      dec_en_n_q <= 1'b1;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2]) begin
          track_period_q <= pwdata[CFG_W-1:0];
        end else begin
          slew_period_q <= pwdata[CFG_W-1:0];
        end
      end
      ra_pos_q   <= ra_pos_d;
      dec_pos_q  <= dec_pos_d;
      ra_rem_q   <= ra_rem_d;
      dec_rem_q  <= dec_rem_d;
      ra_up_q    <= ra_up_d;
      dec_up_q   <= dec_up_d;
      ra_act_q   <= ra_act_d;
      dec_act_q  <= dec_act_d;
      trk_act_q  <= trk_act_d;
      ra_ph_q    <= ra_ph_d;
      dec_ph_q   <= dec_ph_d;
      trk_ph_q   <= trk_ph_d;
      ra_step_q  <= ra_step_d;
      ra_dir_q   <= ra_dir_d;
      ra_en_n_q  <= ra_en_n_d;
      dec_step_q <= dec_step_d;
      dec_dir_q  <= dec_dir_d;
      dec_en_n_q <= dec_en_n_d;
      if (s_fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= {2'b00, dec_pos_d, ra_pos_d, trk_act_d, ra_act_d || dec_act_d,
                     dec_en_n_d, dec_dir_d, dec_step_d, ra_en_n_d, ra_dir_d, ra_step_d};
    end
  end

`ifndef SYNTHESIS
  a_ra_count_matches_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ra_rem_q != '0) == ra_act_q)
    else $error("ra step count and active flag disagree");

  a_dec_count_matches_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_rem_q != '0) == dec_act_q)
    else $error("dec step count and active flag disagree");

  a_dec_active_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_act_q |-> !dec_en_n_q)
    else $error("dec axis stepping with driver disabled");

  a_result_follows_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> out_vld_q)
    else $error("accepted transaction produced no result");
`endif

endmodule
